// ----- rtl/prc_pkg.sv -----
// Shared types and codes for the pixel run coalescer.
// No dependencies; used by the core and by its port checker.
`default_nettype none

package prc_pkg;

  localparam int MAX_WORDS = 40;
  localparam int PIX_SLOTS = 4;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic ITEM_WINDOW = 1'b0;
  localparam logic ITEM_DATA   = 1'b1;

  localparam logic [1:0] CFG_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_COL_OFF = 2'd2;
  localparam logic [1:0] CFG_ROW_OFF = 2'd3;

  typedef enum logic [1:0] {
    RUN_NONE  = 2'd0,
    RUN_ONE   = 2'd1,
    RUN_HORIZ = 2'd2,
    RUN_VERT  = 2'd3
  } run_kind_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WR2   = 5'b00010,
    S_WIN   = 5'b00100,
    S_ONE   = 5'b01000,
    S_DRAIN = 5'b10000
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/pixel_run_coalescer_core.sv -----
// Pixel run coalescer: gathers pixel writes into runs held in a line memory.
// Depends on prc_pkg; checked by prc_checker.
//
// A pixel write that extends the pending run is written while the core stays in S_IDLE;
// turning a single pixel into a line run also passes through S_WR2, since the line memory has
// one write port. A flush or a run break then emits the window item and the data items, and no
// request is taken until the last one is in the output register: S_WIN loads the window item,
// then S_ONE emits a lone pixel, or S_DRAIN reads the run through the single read port of the
// line memory into data words of PIXELS_PER_WORD pixels. Any output stall holds this up.
`default_nettype none

module pixel_run_coalescer_core import prc_pkg::*; #(
  parameter int LINE_DEPTH      = 160,
  parameter int PIXELS_PER_WORD = 4
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         in_operation,
  input  wire  [7:0]  in_x_coord,
  input  wire  [7:0]  in_y_coord,
  input  wire  [15:0] in_pixel_color,
  output logic        out_valid,
  input  wire         out_ready,
  output logic        out_item_kind,
  output logic [7:0]  out_col_start,
  output logic [7:0]  out_col_end,
  output logic [7:0]  out_row_start,
  output logic [7:0]  out_row_end,
  output logic [15:0] out_pix_a,
  output logic [15:0] out_pix_b,
  output logic [15:0] out_pix_c,
  output logic [15:0] out_pix_d,
  output logic [2:0]  out_pix_count,
  output logic        out_last_of_run,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [7:0]  cfg_data
);

  localparam int IW      = $clog2(LINE_DEPTH);
  localparam int MAX_RUN = (LINE_DEPTH < MAX_WORDS * PIXELS_PER_WORD) ?
                           LINE_DEPTH : MAX_WORDS * PIXELS_PER_WORD;
  localparam logic [8:0] LD9       = 9'(LINE_DEPTH);
  localparam logic [8:0] RUN9      = 9'(MAX_RUN);
  localparam logic [1:0] SLOT_LAST = 2'(PIXELS_PER_WORD - 1);

  state_t      state_r, state_nxt;
  run_kind_t   kind_r, kind_nxt;
  logic [7:0]  cmin_r, cmin_nxt, cmax_r, cmax_nxt;
  logic [7:0]  rmin_r, rmin_nxt, rmax_r, rmax_nxt;
  logic [15:0] color_r, color_nxt;
  logic [7:0]  width_r, height_r;
  logic [5:0]  coff_r, roff_r;

  logic        new_vld_r, new_vld_nxt;
  logic [7:0]  new_x_r, new_x_nxt, new_y_r, new_y_nxt;
  logic [15:0] new_c_r, new_c_nxt;
  logic [IW-1:0] wr2_idx_r, wr2_idx_nxt;
  logic [15:0]   wr2_data_r, wr2_data_nxt;

  logic [IW-1:0] rd_idx_r, rd_idx_nxt, hi_r, hi_nxt;
  logic          more_r, more_nxt;
  logic [1:0]    slot_r, slot_nxt;
  logic          rdv_r, rdv_nxt;
  logic [1:0]    rd_slot_r, rd_slot_nxt;
  logic          rd_wlast_r, rd_wlast_nxt, rd_rlast_r, rd_rlast_nxt;
  logic [15:0]   word_r [PIX_SLOTS];
  logic [15:0]   word_nxt [PIX_SLOTS];
  logic [2:0]    word_cnt_r, word_cnt_nxt;
  logic          word_full_r, word_full_nxt, word_rlast_r, word_rlast_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_kind_r, out_kind_nxt;
  logic [7:0]  out_cs_r, out_cs_nxt, out_ce_r, out_ce_nxt;
  logic [7:0]  out_rs_r, out_rs_nxt, out_re_r, out_re_nxt;
  logic [15:0] out_pix_r [PIX_SLOTS];
  logic [15:0] out_pix_nxt [PIX_SLOTS];
  logic [2:0]  out_cnt_r, out_cnt_nxt;
  logic        out_last_r, out_last_nxt;

  logic [15:0]   line_mem [LINE_DEPTH];
  logic [15:0]   rd_data_r;
  logic          mem_we, mem_re;
  logic [IW-1:0] mem_wa;
  logic [15:0]   mem_wd;

  logic [8:0] x9, y9, cmin9, cmax9, rmin9, rmax9;
  logic       x_ok, y_ok, in_range, one_h, one_v, h_ext, v_ext;
  logic [7:0] h_nmin, h_nmax, v_nmin, v_nmax;
  logic [8:0] h_span, v_span;
  logic       out_free, push, issue, wlast, finish;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  assign x9    = {1'b0, in_x_coord};
  assign y9    = {1'b0, in_y_coord};
  assign cmin9 = {1'b0, cmin_r};
  assign cmax9 = {1'b0, cmax_r};
  assign rmin9 = {1'b0, rmin_r};
  assign rmax9 = {1'b0, rmax_r};
  assign x_ok  = x9 < LD9;
  assign y_ok  = y9 < LD9;
  assign in_range = (in_x_coord < width_r) && (in_y_coord < height_r);

  assign one_h = (in_y_coord == rmin_r) && ((x9 + 9'd1 == cmin9) || (x9 == cmin9 + 9'd1))
                 && x_ok && (cmin9 < LD9);
  assign one_v = (in_x_coord == cmin_r) && ((y9 + 9'd1 == rmin9) || (y9 == rmin9 + 9'd1))
                 && y_ok && (rmin9 < LD9);

  assign h_nmin = (in_x_coord < cmin_r) ? in_x_coord : cmin_r;
  assign h_nmax = (in_x_coord > cmax_r) ? in_x_coord : cmax_r;
  assign h_span = {1'b0, h_nmax} - {1'b0, h_nmin} + 9'd1;
  assign h_ext  = (in_y_coord == rmin_r) && (x9 + 9'd1 >= cmin9) && (x9 <= cmax9 + 9'd1)
                  && x_ok && (h_span <= RUN9);

  assign v_nmin = (in_y_coord < rmin_r) ? in_y_coord : rmin_r;
  assign v_nmax = (in_y_coord > rmax_r) ? in_y_coord : rmax_r;
  assign v_span = {1'b0, v_nmax} - {1'b0, v_nmin} + 9'd1;
  assign v_ext  = (in_x_coord == cmin_r) && (y9 + 9'd1 >= rmin9) && (y9 <= rmax9 + 9'd1)
                  && y_ok && (v_span <= RUN9);

  assign out_free = !out_valid_r || out_ready;
  assign push     = (state_r == S_DRAIN) && word_full_r && out_free;
  assign issue    = (state_r == S_DRAIN) && more_r && (!word_full_r || push)
                    && !(rdv_r && rd_wlast_r);
  assign wlast    = (slot_r == SLOT_LAST) || (rd_idx_r == hi_r);

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    cmin_nxt       = cmin_r;
    cmax_nxt       = cmax_r;
    rmin_nxt       = rmin_r;
    rmax_nxt       = rmax_r;
    color_nxt      = color_r;
    new_vld_nxt    = new_vld_r;
    new_x_nxt      = new_x_r;
    new_y_nxt      = new_y_r;
    new_c_nxt      = new_c_r;
    wr2_idx_nxt    = wr2_idx_r;
    wr2_data_nxt   = wr2_data_r;
    rd_idx_nxt     = rd_idx_r;
    hi_nxt         = hi_r;
    more_nxt       = more_r;
    slot_nxt       = slot_r;
    rdv_nxt        = 1'b0;
    rd_slot_nxt    = rd_slot_r;
    rd_wlast_nxt   = rd_wlast_r;
    rd_rlast_nxt   = rd_rlast_r;
    word_nxt       = word_r;
    word_cnt_nxt   = word_cnt_r;
    word_full_nxt  = word_full_r;
    word_rlast_nxt = word_rlast_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_kind_nxt   = out_kind_r;
    out_cs_nxt     = out_cs_r;
    out_ce_nxt     = out_ce_r;
    out_rs_nxt     = out_rs_r;
    out_re_nxt     = out_re_r;
    out_pix_nxt    = out_pix_r;
    out_cnt_nxt    = out_cnt_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_wa         = wr2_idx_r;
    mem_wd         = wr2_data_r;
    mem_re         = 1'b0;
    finish         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_operation == OP_FLUSH) begin
            if (kind_r != RUN_NONE) begin
              new_vld_nxt = 1'b0;
              state_nxt   = S_WIN;
            end
          end else if (in_range) begin
            priority if (kind_r == RUN_ONE && one_h) begin
              kind_nxt     = RUN_HORIZ;
              mem_we       = 1'b1;
              mem_wa       = cmin_r[IW-1:0];
              mem_wd       = color_r;
              wr2_idx_nxt  = in_x_coord[IW-1:0];
              wr2_data_nxt = in_pixel_color;
              state_nxt    = S_WR2;
              if (in_x_coord < cmin_r) begin
                cmin_nxt = in_x_coord;
              end else begin
                cmax_nxt = in_x_coord;
              end
            end else if (kind_r == RUN_ONE && one_v) begin
              kind_nxt     = RUN_VERT;
              mem_we       = 1'b1;
              mem_wa       = rmin_r[IW-1:0];
              mem_wd       = color_r;
              wr2_idx_nxt  = in_y_coord[IW-1:0];
              wr2_data_nxt = in_pixel_color;
              state_nxt    = S_WR2;
              if (in_y_coord < rmin_r) begin
                rmin_nxt = in_y_coord;
              end else begin
                rmax_nxt = in_y_coord;
              end
            end else if (kind_r == RUN_HORIZ && h_ext) begin
              mem_we   = 1'b1;
              mem_wa   = in_x_coord[IW-1:0];
              mem_wd   = in_pixel_color;
              cmin_nxt = h_nmin;
              cmax_nxt = h_nmax;
            end else if (kind_r == RUN_VERT && v_ext) begin
              mem_we   = 1'b1;
              mem_wa   = in_y_coord[IW-1:0];
              mem_wd   = in_pixel_color;
              rmin_nxt = v_nmin;
              rmax_nxt = v_nmax;
            end else if (kind_r != RUN_NONE) begin
              new_vld_nxt = 1'b1;
              new_x_nxt   = in_x_coord;
              new_y_nxt   = in_y_coord;
              new_c_nxt   = in_pixel_color;
              state_nxt   = S_WIN;
            end else begin
              kind_nxt  = RUN_ONE;
              cmin_nxt  = in_x_coord;
              cmax_nxt  = in_x_coord;
              rmin_nxt  = in_y_coord;
              rmax_nxt  = in_y_coord;
              color_nxt = in_pixel_color;
            end
          end
        end
      end
      S_WR2: begin
        mem_we    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_WIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = ITEM_WINDOW;
          out_cs_nxt    = cmin_r + {2'b00, coff_r};
          out_ce_nxt    = cmax_r + {2'b00, coff_r};
          out_rs_nxt    = rmin_r + {2'b00, roff_r};
          out_re_nxt    = rmax_r + {2'b00, roff_r};
          for (int i = 0; i < PIX_SLOTS; i++) begin
            out_pix_nxt[i] = 16'd0;
          end
          out_cnt_nxt   = 3'd0;
          out_last_nxt  = 1'b0;
          if (kind_r == RUN_ONE) begin
            state_nxt = S_ONE;
          end else begin
            state_nxt     = S_DRAIN;
            rd_idx_nxt    = (kind_r == RUN_HORIZ) ? cmin_r[IW-1:0] : rmin_r[IW-1:0];
            hi_nxt        = (kind_r == RUN_HORIZ) ? cmax_r[IW-1:0] : rmax_r[IW-1:0];
            more_nxt      = 1'b1;
            slot_nxt      = 2'd0;
            word_full_nxt = 1'b0;
          end
        end
      end
      S_ONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = ITEM_DATA;
          out_cs_nxt    = 8'd0;
          out_ce_nxt    = 8'd0;
          out_rs_nxt    = 8'd0;
          out_re_nxt    = 8'd0;
          for (int i = 0; i < PIX_SLOTS; i++) begin
            out_pix_nxt[i] = 16'd0;
          end
          out_pix_nxt[0] = color_r;
          out_cnt_nxt    = 3'd1;
          out_last_nxt   = 1'b1;
          finish         = 1'b1;
        end
      end
      S_DRAIN: begin
        if (push) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = ITEM_DATA;
          out_cs_nxt    = 8'd0;
          out_ce_nxt    = 8'd0;
          out_rs_nxt    = 8'd0;
          out_re_nxt    = 8'd0;
          out_pix_nxt   = word_r;
          out_cnt_nxt   = word_cnt_r;
          out_last_nxt  = word_rlast_r;
          word_full_nxt = 1'b0;
          finish        = word_rlast_r;
        end
        if (rdv_r) begin
          for (int i = 0; i < PIX_SLOTS; i++) begin
            if (rd_slot_r == 2'(i)) begin
              word_nxt[i] = rd_data_r;
            end else if (rd_slot_r == 2'd0) begin
              word_nxt[i] = 16'd0;
            end
          end
          word_cnt_nxt = {1'b0, rd_slot_r} + 3'd1;
          if (rd_wlast_r) begin
            word_full_nxt  = 1'b1;
            word_rlast_nxt = rd_rlast_r;
          end
        end
        if (issue) begin
          mem_re       = 1'b1;
          rdv_nxt      = 1'b1;
          rd_slot_nxt  = slot_r;
          rd_wlast_nxt = wlast;
          rd_rlast_nxt = (rd_idx_r == hi_r);
          rd_idx_nxt   = rd_idx_r + 1'b1;
          slot_nxt     = wlast ? 2'd0 : slot_r + 2'd1;
          if (rd_idx_r == hi_r) begin
            more_nxt = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (finish) begin
      state_nxt = S_IDLE;
      kind_nxt  = RUN_NONE;
      cmin_nxt  = width_r - 8'd1;
      cmax_nxt  = 8'd0;
      rmin_nxt  = height_r - 8'd1;
      rmax_nxt  = 8'd0;
      if (new_vld_r) begin
        kind_nxt    = RUN_ONE;
        cmin_nxt    = new_x_r;
        cmax_nxt    = new_x_r;
        rmin_nxt    = new_y_r;
        rmax_nxt    = new_y_r;
        color_nxt   = new_c_r;
        new_vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kind_r      <= RUN_NONE;
      cmin_r      <= 8'd127;
      cmax_r      <= 8'd0;
      rmin_r      <= 8'd159;
      rmax_r      <= 8'd0;
      color_r     <= 16'd0;
      new_vld_r   <= 1'b0;
      more_r      <= 1'b0;
      rdv_r       <= 1'b0;
      word_full_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      cmin_r      <= cmin_nxt;
      cmax_r      <= cmax_nxt;
      rmin_r      <= rmin_nxt;
      rmax_r      <= rmax_nxt;
      color_r     <= color_nxt;
      new_vld_r   <= new_vld_nxt;
      more_r      <= more_nxt;
      rdv_r       <= rdv_nxt;
      word_full_r <= word_full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    new_x_r      <= new_x_nxt;
    new_y_r      <= new_y_nxt;
    new_c_r      <= new_c_nxt;
    wr2_idx_r    <= wr2_idx_nxt;
    wr2_data_r   <= wr2_data_nxt;
    rd_idx_r     <= rd_idx_nxt;
    hi_r         <= hi_nxt;
    slot_r       <= slot_nxt;
    rd_slot_r    <= rd_slot_nxt;
    rd_wlast_r   <= rd_wlast_nxt;
    rd_rlast_r   <= rd_rlast_nxt;
    word_r       <= word_nxt;
    word_cnt_r   <= word_cnt_nxt;
    word_rlast_r <= word_rlast_nxt;
    out_kind_r   <= out_kind_nxt;
    out_cs_r     <= out_cs_nxt;
    out_ce_r     <= out_ce_nxt;
    out_rs_r     <= out_rs_nxt;
    out_re_r     <= out_re_nxt;
    out_pix_r    <= out_pix_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 8'd128;
      height_r <= 8'd160;
      coff_r   <= 6'd0;
      roff_r   <= 6'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WIDTH:   width_r  <= cfg_data;
        CFG_HEIGHT:  height_r <= cfg_data;
        CFG_COL_OFF: coff_r   <= cfg_data[5:0];
        CFG_ROW_OFF: roff_r   <= cfg_data[5:0];
        default:     width_r  <= width_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= line_mem[rd_idx_r];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_item_kind   = out_kind_r;
  assign out_col_start   = out_cs_r;
  assign out_col_end     = out_ce_r;
  assign out_row_start   = out_rs_r;
  assign out_row_end     = out_re_r;
  assign out_pix_a       = out_pix_r[0];
  assign out_pix_b       = out_pix_r[1];
  assign out_pix_c       = out_pix_r[2];
  assign out_pix_d       = out_pix_r[3];
  assign out_pix_count   = out_cnt_r;
  assign out_last_of_run = out_last_r;

endmodule

`default_nettype wire

// ----- rtl/prc_checker.sv -----
// Port-level checks on the pixel run coalescer, bound to its top level.
// Depends on prc_pkg and on pixel_run_coalescer_core.
`default_nettype none

module prc_checker import prc_pkg::*; #(
  parameter int PIXELS_PER_WORD = 4
) (
  input wire        clk,
  input wire        rst_n,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire        out_item_kind,
  input wire [2:0]  out_pix_count,
  input wire        out_last_of_run,
  input wire [15:0] out_pix_a
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pix_a) && $stable(out_pix_count))
    else $error("stalled result changed");

  a_window_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_kind == ITEM_WINDOW |-> out_pix_count == 3'd0 && !out_last_of_run)
    else $error("window item carries pixel data");

  a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_kind == ITEM_DATA |->
      out_pix_count != 3'd0 && out_pix_count <= 3'(PIXELS_PER_WORD))
    else $error("data item pixel count out of range");

  a_busy_after_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_item_kind == ITEM_WINDOW |-> !in_ready)
    else $error("request taken before run was fully emitted");

endmodule

bind pixel_run_coalescer_core prc_checker #(
  .PIXELS_PER_WORD(PIXELS_PER_WORD)
) u_prc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_item_kind   (out_item_kind),
  .out_pix_count   (out_pix_count),
  .out_last_of_run (out_last_of_run),
  .out_pix_a       (out_pix_a)
);

`default_nettype wire
